[design/spc_pkg.sv]
// shared types and constants of the sparse polynomial combiner
package spc_pkg;

	localparam int OUT_LIMIT = 32;

	localparam logic [1:0] MODE_SUM = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;
	localparam logic [1:0] MODE_MUL = 2'd2;
	localparam logic [1:0] MODE_RSV = 2'd3;

	typedef struct packed {
		logic latch_term;
		logic tgt_set;
		logic tgt_prod;
		logic k_clr;
		logic k_inc;
		logic i_clr;
		logic i_inc;
		logic j_clr;
		logic j_inc;
		logic rd_i;
		logic append;
		logic buf_append;
		logic wr_merge;
		logic latch_a;
		logic mul;
		logic pc_clr;
		logic copy_wr;
		logic copy_done;
		logic finish_poly;
		logic emit_ld;
		logic emit_clr;
	} spc_cmd_t;

	typedef struct packed {
		logic       k_end;
		logic       match;
		logic       i_end;
		logic       j_end;
		logic       first;
		logic [1:0] mode;
		logic       pe;
		logic       je;
		logic       tgt_prod;
		logic       out_last;
	} spc_stat_t;

endpackage

[design/spc_datapath.sv]
// term tables, counters, multiplier and output register of the combiner
module spc_datapath #(
	parameter int MAX_TERMS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spc_pkg::spc_cmd_t cmd,
	output spc_pkg::spc_stat_t st,
	input  logic [31:0]       in_coef,
	input  logic [15:0]       in_exp,
	input  logic              in_pe,
	input  logic              in_je,
	input  logic [1:0]        mode,
	output logic [31:0]       out_coef,
	output logic [15:0]       out_exp,
	output logic              out_last,
	output logic              out_ovf
);
	import spc_pkg::*;

	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW = $clog2(MAX_TERMS + 1);

	logic [31:0] acc_coef_m [MAX_TERMS];
	logic [15:0] acc_exp_m  [MAX_TERMS];
	logic [31:0] buf_coef_m [MAX_TERMS];
	logic [15:0] buf_exp_m  [MAX_TERMS];
	logic [31:0] prod_coef_m [MAX_TERMS];
	logic [15:0] prod_exp_m  [MAX_TERMS];

	logic [31:0] acc_rd_coef_q, buf_rd_coef_q, prod_rd_coef_q;
	logic [15:0] acc_rd_exp_q, buf_rd_exp_q, prod_rd_exp_q;

	logic [CW-1:0] acc_cnt_q, buf_cnt_q, prod_cnt_q;
	logic [CW-1:0] k_q, i_q, j_q;
	logic          tgt_prod_q, first_q, dropped_q;
	logic [1:0]    mode_q;
	logic          pe_q, je_q;
	logic [31:0]   op_coef_q, a_coef_q;
	logic [15:0]   op_exp_q, a_exp_q;
	logic [31:0]   out_coef_q;
	logic [15:0]   out_exp_q;
	logic          out_last_q, out_ovf_q;

	logic [CW-1:0] tgt_cnt;
	logic          tgt_full, buf_full;
	logic [31:0]   rd_coef;
	logic [15:0]   rd_exp;
	logic [AW-1:0] acc_raddr;
	logic          acc_we, prod_we, buf_we;
	logic [AW-1:0] acc_waddr, prod_waddr;
	logic [31:0]   acc_wcoef, prod_wcoef;
	logic [15:0]   acc_wexp, prod_wexp;
	logic [31:0]   mul_lo;
	logic [31:0]   kp1, cnt_ext;

	assign tgt_cnt  = tgt_prod_q ? prod_cnt_q : acc_cnt_q;
	assign tgt_full = tgt_cnt == CW'(MAX_TERMS);
	assign buf_full = buf_cnt_q == CW'(MAX_TERMS);
	assign rd_coef  = tgt_prod_q ? prod_rd_coef_q : acc_rd_coef_q;
	assign rd_exp   = tgt_prod_q ? prod_rd_exp_q : acc_rd_exp_q;
	assign acc_raddr = cmd.rd_i ? i_q[AW-1:0] : k_q[AW-1:0];
	assign mul_lo   = a_coef_q * buf_rd_coef_q;
	assign kp1      = 32'(k_q) + 32'd1;
	assign cnt_ext  = 32'(acc_cnt_q);

	assign acc_we = (!tgt_prod_q && ((cmd.append && !tgt_full) || cmd.wr_merge)) || cmd.copy_wr;
	assign acc_waddr = cmd.append ? acc_cnt_q[AW-1:0] : k_q[AW-1:0];
	assign acc_wcoef = cmd.copy_wr ? prod_rd_coef_q :
		(cmd.append ? op_coef_q : rd_coef + op_coef_q);
	assign acc_wexp  = cmd.copy_wr ? prod_rd_exp_q : (cmd.append ? op_exp_q : rd_exp);

	assign prod_we = tgt_prod_q && ((cmd.append && !tgt_full) || cmd.wr_merge);
	assign prod_waddr = cmd.append ? prod_cnt_q[AW-1:0] : k_q[AW-1:0];
	assign prod_wcoef = cmd.append ? op_coef_q : rd_coef + op_coef_q;
	assign prod_wexp  = cmd.append ? op_exp_q : rd_exp;

	assign buf_we = cmd.buf_append && !buf_full;

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_coef_m[acc_waddr] <= acc_wcoef;
			acc_exp_m[acc_waddr]  <= acc_wexp;
		end
		acc_rd_coef_q <= acc_coef_m[acc_raddr];
		acc_rd_exp_q  <= acc_exp_m[acc_raddr];
	end

	always_ff @(posedge clk) begin
		if (prod_we) begin
			prod_coef_m[prod_waddr] <= prod_wcoef;
			prod_exp_m[prod_waddr]  <= prod_wexp;
		end
		prod_rd_coef_q <= prod_coef_m[k_q[AW-1:0]];
		prod_rd_exp_q  <= prod_exp_m[k_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_coef_m[buf_cnt_q[AW-1:0]] <= op_coef_q;
			buf_exp_m[buf_cnt_q[AW-1:0]]  <= op_exp_q;
		end
		buf_rd_coef_q <= buf_coef_m[j_q[AW-1:0]];
		buf_rd_exp_q  <= buf_exp_m[j_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_cnt_q  <= '0;
			buf_cnt_q  <= '0;
			prod_cnt_q <= '0;
			k_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			tgt_prod_q <= 1'b0;
			first_q    <= 1'b1;
			dropped_q  <= 1'b0;
			mode_q     <= MODE_SUM;
			pe_q       <= 1'b0;
			je_q       <= 1'b0;
		end else begin
			if (cmd.latch_term) begin
				mode_q <= mode;
				pe_q   <= in_pe;
				je_q   <= in_je;
			end
			if (cmd.tgt_set) tgt_prod_q <= cmd.tgt_prod;
			if (cmd.k_clr) k_q <= '0;
			else if (cmd.k_inc) k_q <= k_q + CW'(1);
			if (cmd.i_clr) i_q <= '0;
			else if (cmd.i_inc) i_q <= i_q + CW'(1);
			if (cmd.j_clr) j_q <= '0;
			else if (cmd.j_inc) j_q <= j_q + CW'(1);
			if (cmd.emit_clr) acc_cnt_q <= '0;
			else if (cmd.copy_done) acc_cnt_q <= prod_cnt_q;
			else if (cmd.append && !tgt_prod_q && !tgt_full) acc_cnt_q <= acc_cnt_q + CW'(1);
			if (cmd.pc_clr) prod_cnt_q <= '0;
			else if (cmd.append && tgt_prod_q && !tgt_full) prod_cnt_q <= prod_cnt_q + CW'(1);
			if (cmd.finish_poly) buf_cnt_q <= '0;
			else if (buf_we) buf_cnt_q <= buf_cnt_q + CW'(1);
			if (cmd.emit_clr) dropped_q <= 1'b0;
			else if ((cmd.append && tgt_full) || (cmd.buf_append && buf_full)) dropped_q <= 1'b1;
			if (cmd.emit_clr) first_q <= 1'b1;
			else if (cmd.finish_poly) first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_term) begin
			op_coef_q <= (mode == MODE_SUB && !first_q) ? 32'd0 - in_coef : in_coef;
			op_exp_q  <= in_exp;
		end else if (cmd.mul) begin
			op_coef_q <= mul_lo;
			op_exp_q  <= a_exp_q + buf_rd_exp_q;
		end
		if (cmd.latch_a) begin
			a_coef_q <= acc_rd_coef_q;
			a_exp_q  <= acc_rd_exp_q;
		end
		if (cmd.emit_ld) begin
			out_ovf_q <= dropped_q || (cnt_ext > 32'(OUT_LIMIT));
			if (acc_cnt_q == '0) begin
				out_coef_q <= '0;
				out_exp_q  <= '0;
				out_last_q <= 1'b1;
			end else begin
				out_coef_q <= acc_rd_coef_q;
				out_exp_q  <= acc_rd_exp_q;
				out_last_q <= (kp1 == cnt_ext) || (kp1 == 32'(OUT_LIMIT));
			end
		end
	end

	assign st.k_end    = k_q == tgt_cnt;
	assign st.match    = rd_exp == op_exp_q;
	assign st.i_end    = i_q == acc_cnt_q;
	assign st.j_end    = j_q == buf_cnt_q;
	assign st.first    = first_q;
	assign st.mode     = mode_q;
	assign st.pe       = pe_q;
	assign st.je       = je_q;
	assign st.tgt_prod = tgt_prod_q;
	assign st.out_last = out_last_q;

	assign out_coef = out_coef_q;
	assign out_exp  = out_exp_q;
	assign out_last = out_last_q;
	assign out_ovf  = out_ovf_q;

endmodule

[design/spc_ctrl.sv]
// sequencer that steps the combiner datapath through merge, product, copy and emit
module spc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  spc_pkg::spc_stat_t st,
	output spc_pkg::spc_cmd_t  cmd
);
	import spc_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_DISP  = 16'h0002,
		S_M_RD  = 16'h0004,
		S_M_CMP = 16'h0008,
		S_POST  = 16'h0010,
		S_P_A   = 16'h0020,
		S_P_B   = 16'h0040,
		S_P_C   = 16'h0080,
		S_P_D   = 16'h0100,
		S_C_RD  = 16'h0200,
		S_C_WR  = 16'h0400,
		S_FIN   = 16'h0800,
		S_E_RD  = 16'h1000,
		S_E_LD  = 16'h2000,
		S_E_W   = 16'h4000,
		S_SPARE = 16'h8000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = state_q == S_E_W;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.tgt_set = 1'b1;
				if (in_valid) begin
					cmd.latch_term = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (st.mode == MODE_SUM || (st.mode == MODE_SUB && !st.first)) begin
					cmd.k_clr = 1'b1;
					state_d = S_M_RD;
				end else if (st.first) begin
					cmd.append = 1'b1;
					state_d = S_POST;
				end else begin
					cmd.buf_append = 1'b1;
					state_d = S_POST;
				end
			end
			S_M_RD: begin
				if (st.k_end) begin
					cmd.append = 1'b1;
					state_d = st.tgt_prod ? S_P_C : S_POST;
				end else begin
					state_d = S_M_CMP;
				end
			end
			S_M_CMP: begin
				if (st.match) begin
					cmd.wr_merge = 1'b1;
					state_d = st.tgt_prod ? S_P_C : S_POST;
				end else begin
					cmd.k_inc = 1'b1;
					state_d = S_M_RD;
				end
			end
			S_POST: begin
				if (!st.pe) begin
					state_d = S_IDLE;
				end else if (st.mode == MODE_MUL && !st.first) begin
					cmd.i_clr    = 1'b1;
					cmd.pc_clr   = 1'b1;
					cmd.tgt_set  = 1'b1;
					cmd.tgt_prod = 1'b1;
					state_d = S_P_A;
				end else begin
					state_d = S_FIN;
				end
			end
			S_P_A: begin
				cmd.rd_i = 1'b1;
				if (st.i_end) begin
					cmd.k_clr = 1'b1;
					state_d = S_C_RD;
				end else begin
					cmd.j_clr = 1'b1;
					state_d = S_P_B;
				end
			end
			S_P_B: begin
				cmd.latch_a = 1'b1;
				state_d = S_P_C;
			end
			S_P_C: begin
				if (st.j_end) begin
					cmd.i_inc = 1'b1;
					state_d = S_P_A;
				end else begin
					state_d = S_P_D;
				end
			end
			S_P_D: begin
				cmd.mul   = 1'b1;
				cmd.j_inc = 1'b1;
				cmd.k_clr = 1'b1;
				state_d = S_M_RD;
			end
			S_C_RD: begin
				if (st.k_end) begin
					cmd.copy_done = 1'b1;
					cmd.tgt_set   = 1'b1;
					state_d = S_FIN;
				end else begin
					state_d = S_C_WR;
				end
			end
			S_C_WR: begin
				cmd.copy_wr = 1'b1;
				cmd.k_inc   = 1'b1;
				state_d = S_C_RD;
			end
			S_FIN: begin
				cmd.finish_poly = 1'b1;
				if (st.je) begin
					cmd.k_clr = 1'b1;
					state_d = S_E_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_E_RD: state_d = S_E_LD;
			S_E_LD: begin
				cmd.emit_ld = 1'b1;
				state_d = S_E_W;
			end
			S_E_W: begin
				if (out_ready) begin
					if (st.out_last) begin
						cmd.emit_clr = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.k_inc = 1'b1;
						state_d = S_E_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[design/sparse_polynomial_combiner.sv]
// top level of the sparse polynomial combiner: config register, controller and datapath
//
// Terms come in on the s_axis channel, one term per item, polynomial after
// polynomial; tlast ends a polynomial and tuser with tlast ends the job.
// cfg_we/cfg_wdata set the combine mode (sum, first minus rest, product)
// and must only be written while the block is idle.
// A term may be appended without a search; otherwise it searches the term
// table entry by entry, set by the single read port of the term table, and
// is then merged into a matching entry or appended. In product mode the
// end of each further polynomial multiplies every cross term and merges
// it into the product table one at a time.
// Results go out on m_axis only after the job's last term, one item at a
// time; tlast marks the final term and tuser carries the overflow flag.
// A stalled receiver holds the block and no new term is taken until the
// job's results are all gone.
// Reset empties the tables at once (counts cleared, no clearing pass) and
// sets the mode to sum.
module sparse_polynomial_combiner #(
	parameter int MAX_TERMS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // term_coefficient, term_exponent
	input  logic        s_axis_tlast,
	input  logic        s_axis_tuser,  // job_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // out_coefficient, out_exponent
	output logic        m_axis_tlast,
	output logic        m_axis_tuser,  // overflow
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata
);
	import spc_pkg::*;

	logic [1:0]  mode_q;
	logic [1:0]  eff_mode;
	spc_cmd_t    cmd;
	spc_stat_t   st;
	logic [31:0] out_coef;
	logic [15:0] out_exp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= MODE_SUM;
		else if (cfg_we) mode_q <= cfg_wdata;
	end

	assign eff_mode = (mode_q == MODE_RSV) ? MODE_SUM : mode_q;

	spc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.st        (st),
		.cmd       (cmd)
	);

	spc_datapath #(.MAX_TERMS(MAX_TERMS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.in_coef  (s_axis_tdata[31:0]),
		.in_exp   (s_axis_tdata[47:32]),
		.in_pe    (s_axis_tlast),
		.in_je    (s_axis_tuser),
		.mode     (eff_mode),
		.out_coef (out_coef),
		.out_exp  (out_exp),
		.out_last (m_axis_tlast),
		.out_ovf  (m_axis_tuser)
	);

	assign m_axis_tdata = {out_exp, out_coef};

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken while a result is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("ready right after an accepted item");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (s_axis_tready && !m_axis_tvalid))
		else $error("not idle after the final result");

	a_result_only_after_job: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !s_axis_tready)
		else $error("result shown while idle");

endmodule
